FILE: rtl/ffe_pkg.sv
// Shared constants, command codes and controller/datapath interface types.
`timescale 1ns / 1ps

package ffe_pkg;

    // Field widths of one input beat and one result beat.
    localparam int FIELD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int CMD_W      = 3;
    localparam int IN_DATA_W  = 6 * FIELD_W + COLOR_W;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Clipped coordinates never exceed the 9-bit size registers.
    localparam int COORD_W    = CFG_DATA_W;
    localparam int COORD_MAX  = (2 ** COORD_W) - 1;

    // Raw rectangle bounds need room for origin plus size minus one.
    localparam int EXT_W      = FIELD_W + 2;

    // Default store geometry.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Reset value of both size registers.
    localparam logic [CFG_DATA_W-1:0] FB_SIZE_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 1'b1;

    // Drawing commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_READ  = 3'd2,
        CMD_FILL  = 3'd3,
        CMD_LINE  = 3'd4
    } cmd_t;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic clip_en;
        logic base_en;
        logic fill_en;
        logic rd_en;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_read;
        logic nonempty;
        logic box_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/ffe_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module ffe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: a write or a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ffe_ctrl.sv
// Command sequencer: accepts a beat, clips, sets up the row base, then reads, fills a nonempty box or returns to idle.
`timescale 1ns / 1ps

module ffe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffe_pkg::dp_stat_t stat_i,
    output ffe_pkg::dp_cmd_t  cmd_o
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLIP  = 6'b000010,
        ST_BASE  = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_RDATA = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath strobes.
    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready       = 1'b1;
                cmd_o.load_en = s_valid;
                if (s_valid)
                begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                cmd_o.clip_en = 1'b1;
                state_next    = ST_BASE;
            end
            ST_BASE:
            begin
                cmd_o.base_en = 1'b1;
                if (stat_i.is_read)
                begin
                    state_next = ST_READ;
                end
                else if (stat_i.nonempty)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                cmd_o.fill_en = 1'b1;
                if (stat_i.box_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd_o.rd_en = 1'b1;
                state_next  = ST_RDATA;
            end
            ST_RDATA:
            begin
                // Hold the read word until the output register frees up.
                if (stat_i.out_free)
                begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A fill only runs over a box that survived clipping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> stat_i.nonempty)
    else $error("fill running over an empty box");

    // A read result waits while the output register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDATA && !stat_i.out_free) |=> (state_reg == ST_RDATA))
    else $error("read result dropped under output stall");

    // No new beat is taken while memory work is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_ready |-> (!cmd_o.fill_en && !cmd_o.rd_en && !cmd_o.out_load))
    else $error("input accepted during memory access");

endmodule

FILE: rtl/ffe_datapath.sv
// Size registers, clipping, row address generation, pixel store and output register.
`timescale 1ns / 1ps

module ffe_datapath #(
    parameter int MAX_WIDTH  = ffe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ffe_pkg::IN_DATA_W-1:0]    s_data,
    input  logic [ffe_pkg::CMD_W-1:0]        s_user,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ffe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ffe_pkg::OUT_DATA_W-1:0]   m_data,
    input  ffe_pkg::dp_cmd_t                 cmd_i,
    output ffe_pkg::dp_stat_t                stat_o
);

    localparam int CW    = ffe_pkg::COORD_W;
    localparam int EW    = ffe_pkg::EXT_W;
    localparam int FW    = ffe_pkg::FIELD_W;
    localparam int PW    = 2 * CW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CAP = (MAX_WIDTH  > ffe_pkg::COORD_MAX) ? ffe_pkg::COORD_MAX : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > ffe_pkg::COORD_MAX) ? ffe_pkg::COORD_MAX : MAX_HEIGHT;

    // Size registers and the visible area they select.
    logic [CW-1:0] fb_width_reg;
    logic [CW-1:0] fb_height_reg;
    logic [CW-1:0] vis_w;
    logic [CW-1:0] vis_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= ffe_pkg::FB_SIZE_RESET;
            fb_height_reg <= ffe_pkg::FB_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ffe_pkg::REG_FB_WIDTH:  fb_width_reg  <= cfg_data;
                ffe_pkg::REG_FB_HEIGHT: fb_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign vis_w = (fb_width_reg  < CW'(W_CAP)) ? fb_width_reg  : CW'(W_CAP);
    assign vis_h = (fb_height_reg < CW'(H_CAP)) ? fb_height_reg : CW'(H_CAP);

    logic signed [EW-1:0] w_last;
    logic signed [EW-1:0] h_last;

    assign w_last = signed'({{(EW - CW){1'b0}}, vis_w}) - EW'(1);
    assign h_last = signed'({{(EW - CW){1'b0}}, vis_h}) - EW'(1);

    // Unpack the input beat.
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] end_x;
    logic signed [FW-1:0] end_y;
    logic signed [FW-1:0] size_w;
    logic signed [FW-1:0] size_h;
    logic signed [EW-1:0] px_e;
    logic signed [EW-1:0] py_e;
    logic signed [EW-1:0] ex_e;
    logic signed [EW-1:0] ey_e;

    assign pos_x  = signed'(s_data[FW-1:0]);
    assign pos_y  = signed'(s_data[2*FW-1:FW]);
    assign end_x  = signed'(s_data[3*FW-1:2*FW]);
    assign end_y  = signed'(s_data[4*FW-1:3*FW]);
    assign size_w = signed'(s_data[5*FW-1:4*FW]);
    assign size_h = signed'(s_data[6*FW-1:5*FW]);
    assign px_e   = EW'(pos_x);
    assign py_e   = EW'(pos_y);
    assign ex_e   = EW'(end_x);
    assign ey_e   = EW'(end_y);

    // Unclipped inclusive box for each command.
    logic signed [EW-1:0] lo_x;
    logic signed [EW-1:0] hi_x;
    logic signed [EW-1:0] lo_y;
    logic signed [EW-1:0] hi_y;
    logic                 box_ok;

    always_comb
    begin
        lo_x   = px_e;
        hi_x   = px_e;
        lo_y   = py_e;
        hi_y   = py_e;
        box_ok = 1'b0;
        case (ffe_pkg::cmd_t'(s_user))
            ffe_pkg::CMD_CLEAR:
            begin
                lo_x   = EW'(0);
                hi_x   = w_last;
                lo_y   = EW'(0);
                hi_y   = h_last;
                box_ok = 1'b1;
            end
            ffe_pkg::CMD_WRITE, ffe_pkg::CMD_READ:
            begin
                box_ok = 1'b1;
            end
            ffe_pkg::CMD_FILL:
            begin
                hi_x   = px_e + EW'(size_w) - EW'(1);
                hi_y   = py_e + EW'(size_h) - EW'(1);
                box_ok = (size_w > 0) && (size_h > 0);
            end
            ffe_pkg::CMD_LINE:
            begin
                if (pos_x == end_x)
                begin
                    lo_y   = (py_e < ey_e) ? py_e : ey_e;
                    hi_y   = (py_e < ey_e) ? ey_e : py_e;
                    box_ok = 1'b1;
                end
                else if (pos_y == end_y)
                begin
                    lo_x   = (px_e < ex_e) ? px_e : ex_e;
                    hi_x   = (px_e < ex_e) ? ex_e : px_e;
                    box_ok = 1'b1;
                end
            end
            default:
            begin
                box_ok = 1'b0;
            end
        endcase
    end

    // Beat capture.
    logic signed [EW-1:0]           lo_x_reg;
    logic signed [EW-1:0]           hi_x_reg;
    logic signed [EW-1:0]           lo_y_reg;
    logic signed [EW-1:0]           hi_y_reg;
    logic                           box_ok_reg;
    logic                           is_read_reg;
    logic [ffe_pkg::COLOR_W-1:0]    color_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_i.load_en)
        begin
            lo_x_reg    <= lo_x;
            hi_x_reg    <= hi_x;
            lo_y_reg    <= lo_y;
            hi_y_reg    <= hi_y;
            box_ok_reg  <= box_ok;
            is_read_reg <= (ffe_pkg::cmd_t'(s_user) == ffe_pkg::CMD_READ);
            color_reg   <= s_data[ffe_pkg::IN_DATA_W-1:6*FW];
        end
    end

    // Clip the box to the visible area.
    logic signed [EW-1:0] cx0;
    logic signed [EW-1:0] cx1;
    logic signed [EW-1:0] cy0;
    logic signed [EW-1:0] cy1;
    logic [CW-1:0]        x0_reg;
    logic [CW-1:0]        x1_reg;
    logic [CW-1:0]        y0_reg;
    logic [CW-1:0]        y1_reg;
    logic                 nonempty_reg;

    assign cx0 = (lo_x_reg < 0) ? EW'(0) : lo_x_reg;
    assign cy0 = (lo_y_reg < 0) ? EW'(0) : lo_y_reg;
    assign cx1 = (hi_x_reg > w_last) ? w_last : hi_x_reg;
    assign cy1 = (hi_y_reg > h_last) ? h_last : hi_y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_i.clip_en)
        begin
            x0_reg       <= cx0[CW-1:0];
            x1_reg       <= cx1[CW-1:0];
            y0_reg       <= cy0[CW-1:0];
            y1_reg       <= cy1[CW-1:0];
            nonempty_reg <= box_ok_reg && (cx0 <= cx1) && (cy0 <= cy1);
        end
    end

    // Row base from one multiply, then walk the box one pixel a cycle.
    logic [PW-1:0] row_prod;
    logic [AW-1:0] row_base_reg;
    logic [CW-1:0] x_cnt_reg;
    logic [CW-1:0] y_cnt_reg;
    logic [AW-1:0] addr;
    logic          row_end;

    assign row_prod = PW'(y0_reg) * PW'(vis_w);
    assign addr     = row_base_reg + AW'(x_cnt_reg);
    assign row_end  = (x_cnt_reg == x1_reg);

    always_ff @(posedge clk)
    begin
        if (cmd_i.base_en)
        begin
            row_base_reg <= AW'(row_prod);
            x_cnt_reg    <= x0_reg;
            y_cnt_reg    <= y0_reg;
        end
        else if (cmd_i.fill_en)
        begin
            if (row_end)
            begin
                x_cnt_reg    <= x0_reg;
                y_cnt_reg    <= y_cnt_reg + CW'(1);
                row_base_reg <= row_base_reg + AW'(vis_w);
            end
            else
            begin
                x_cnt_reg <= x_cnt_reg + CW'(1);
            end
        end
    end

    // Pixel store.
    logic                        ram_re;
    logic [ffe_pkg::COLOR_W-1:0] ram_rdata;

    assign ram_re = cmd_i.rd_en && nonempty_reg;

    ffe_ram #(
        .WIDTH (ffe_pkg::COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd_i.fill_en),
        .re    (ram_re),
        .addr  (addr),
        .wdata (color_reg),
        .rdata (ram_rdata)
    );

    // Output register; an outside coordinate reads as zero.
    logic                           out_valid_reg;
    logic [ffe_pkg::OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.out_load)
        begin
            out_data_reg <= nonempty_reg ? ram_rdata : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Status to the controller.
    assign stat_o.is_read  = is_read_reg;
    assign stat_o.nonempty = nonempty_reg;
    assign stat_o.box_last = row_end && (y_cnt_reg == y1_reg);
    assign stat_o.out_free = !out_valid_reg || m_ready;

    // Every store access lands inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_i.fill_en || ram_re) |-> (int'(addr) < DEPTH))
    else $error("pixel store address out of range");

    // The fill walk stays inside the clipped box.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.fill_en |-> (x_cnt_reg >= x0_reg && x_cnt_reg <= x1_reg
                           && y_cnt_reg <= y1_reg))
    else $error("fill walk left the clipped box");

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.out_load |-> (!out_valid_reg || m_ready))
    else $error("result overwritten before delivery");

endmodule

FILE: rtl/framebuffer_fill_engine.sv
// Top level of the framebuffer fill engine: controller plus datapath.
//
//  Channel   Direction  Signals                         Contents
//  s_axis    in         tvalid tready tdata tuser       drawing command beat
//  m_axis    out        tvalid tready tdata             read pixel result beat
//  cfg       in         cfg_valid cfg_ready cfg_index   size register write
//                       cfg_data
//
// Clear, fill rectangle and line write the pixel store, a single port, once per
// cycle for each pixel drawn; a write pixel outside the frame writes nothing,
// and a read pixel also waits out any output stall.
// Reset sets both size registers to 256; the pixel store is not cleared.
// A read result waits in the output register; the engine takes a new beat
// once the result is loaded there, and stalls only if the register is full.
`timescale 1ns / 1ps

module framebuffer_fill_engine #(
    parameter int MAX_WIDTH  = ffe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_axis_tdata, low bit up: pos_x, pos_y, end_x, end_y, size_w, size_h, color
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ffe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // s_axis_tuser: cmd
    input  logic [ffe_pkg::CMD_W-1:0]        s_axis_tuser,
    // m_axis_tdata: read_data
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ffe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ffe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ffe_pkg::dp_cmd_t  dp_cmd;
    ffe_pkg::dp_stat_t dp_stat;

    ffe_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat_i  (dp_stat),
        .cmd_o   (dp_cmd)
    );

    ffe_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_data    (s_axis_tdata),
        .s_user    (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .cmd_i     (dp_cmd),
        .stat_o    (dp_stat)
    );

endmodule

FILE: test/tb_framebuffer_fill_engine.sv
// Self-checking testbench for the framebuffer fill engine: directed and random commands.
`timescale 1ns / 1ps

module tb_framebuffer_fill_engine;

    localparam int FIELD_W    = ffe_pkg::FIELD_W;
    localparam int COLOR_W    = ffe_pkg::COLOR_W;
    localparam int CMD_W      = ffe_pkg::CMD_W;
    localparam int IN_DATA_W  = ffe_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = ffe_pkg::OUT_DATA_W;
    localparam int CFG_IDX_W  = ffe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ffe_pkg::CFG_DATA_W;

    localparam int MAX_W = ffe_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H = ffe_pkg::DEF_MAX_HEIGHT;

    // Command codes that the engine must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    // One command beat on s_axis_tdata; pos_x sits in the lowest bits.
    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic signed [FIELD_W-1:0] size_h;
        logic signed [FIELD_W-1:0] size_w;
        logic signed [FIELD_W-1:0] end_y;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_x;
    } draw_fields_t;

    // Stall styles of the result receiver.
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_SPARSE} rx_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the engine: size registers and pixel store.
    logic [CFG_DATA_W-1:0] fb_w_cfg = ffe_pkg::FB_SIZE_RESET;
    logic [CFG_DATA_W-1:0] fb_h_cfg = ffe_pkg::FB_SIZE_RESET;
    logic [COLOR_W-1:0]    pix_store [0:MAX_W*MAX_H-1];
    bit                    pix_written [0:MAX_W*MAX_H-1];
    logic [OUT_DATA_W-1:0] read_expect_q [$];

    int        last_x = 0;
    int        last_y = 0;
    int        fail_count = 0;
    int        items_sent = 0;
    int        reads_checked = 0;
    int        sizes_used = 0;
    int        burst_left = 0;
    bit        gaps_on = 1'b0;
    rx_style_t rx_mode = RX_ALWAYS;
    int        rx_tick = 0;

    framebuffer_fill_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls according to the current style.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_BURSTY: m_axis_tready <= ((rx_tick % 9) < 2);
            default:   m_axis_tready <= ((rx_tick % 37) == 0);
        endcase
    end

    // Every result beat is compared with the oldest expected read value.
    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (read_expect_q.size() == 0)
            begin
                $error("read_data: expected no beat, actual %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = read_expect_q.pop_front();
                reads_checked++;
                if (m_axis_tdata !== want)
                begin
                    $error("read_data: expected %h, actual %h", want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Visible size is the register value capped by the store geometry.
    function automatic int vis_cols();
        return (fb_w_cfg < MAX_W) ? int'(fb_w_cfg) : MAX_W;
    endfunction

    function automatic int vis_rows();
        return (fb_h_cfg < MAX_H) ? int'(fb_h_cfg) : MAX_H;
    endfunction

    function automatic bit on_screen(input int x, input int y);
        return x >= 0 && x < vis_cols() && y >= 0 && y < vis_rows();
    endfunction

    function automatic int pix_addr(input int x, input int y);
        return y * vis_cols() + x;
    endfunction

    // Paint an inclusive box after clipping it to the visible area.
    function automatic void paint_box(input int x0, input int y0, input int x1, input int y1,
                                      input logic [COLOR_W-1:0] c);
        int x;
        int y;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > vis_cols() - 1) x1 = vis_cols() - 1;
        if (y1 > vis_rows() - 1) y1 = vis_rows() - 1;
        for (y = y0; y <= y1; y++)
        begin
            for (x = x0; x <= x1; x++)
            begin
                pix_store[pix_addr(x, y)] = c;
                pix_written[pix_addr(x, y)] = 1'b1;
            end
        end
        // Remember a drawn corner so that random reads can aim at fresh pixels.
        if (x0 <= x1 && y0 <= y1)
        begin
            last_x = $urandom_range(0, 1) ? x0 : x1;
            last_y = $urandom_range(0, 1) ? y0 : y1;
        end
    endfunction

    // Apply one accepted command to the shadow store.
    function automatic void predict_command(input logic [CMD_W-1:0] cmd, input draw_fields_t f);
        int px;
        int py;
        int ex;
        int ey;
        int sw;
        int sh;
        px = int'($signed(f.pos_x));
        py = int'($signed(f.pos_y));
        ex = int'($signed(f.end_x));
        ey = int'($signed(f.end_y));
        sw = int'($signed(f.size_w));
        sh = int'($signed(f.size_h));
        case (cmd)
            ffe_pkg::CMD_CLEAR: paint_box(0, 0, vis_cols() - 1, vis_rows() - 1, f.color);
            ffe_pkg::CMD_WRITE:
                if (on_screen(px, py))
                    paint_box(px, py, px, py, f.color);
            ffe_pkg::CMD_READ:
                read_expect_q.push_back(on_screen(px, py) ? pix_store[pix_addr(px, py)] : '0);
            ffe_pkg::CMD_FILL:
                if (sw > 0 && sh > 0)
                    paint_box(px, py, px + sw - 1, py + sh - 1, f.color);
            ffe_pkg::CMD_LINE:
                if (px == ex)
                    paint_box(px, (py < ey) ? py : ey, px, (py > ey) ? py : ey, f.color);
                else if (py == ey)
                    paint_box((px < ex) ? px : ex, py, (px > ex) ? px : ex, py, f.color);
            default: ;
        endcase
    endfunction

    function automatic draw_fields_t make_fields(input int px, input int py, input int ex,
                                                 input int ey, input int sw, input int sh,
                                                 input logic [COLOR_W-1:0] c);
        draw_fields_t f;
        f.pos_x  = px[FIELD_W-1:0];
        f.pos_y  = py[FIELD_W-1:0];
        f.end_x  = ex[FIELD_W-1:0];
        f.end_y  = ey[FIELD_W-1:0];
        f.size_w = sw[FIELD_W-1:0];
        f.size_h = sh[FIELD_W-1:0];
        f.color  = c;
        return f;
    endfunction

    // Mostly near the visible area, sometimes anywhere or at the field extremes.
    function automatic int rand_coord(input int span);
        int pick;
        logic [FIELD_W-1:0] raw;
        pick = $urandom_range(0, 19);
        raw = FIELD_W'($urandom());
        if (pick < 16)
            return int'($urandom_range(0, span + 3)) - 2;
        if (pick < 18)
            return int'($signed(raw));
        if (pick == 18)
            return $urandom_range(0, 1) ? -32768 : -1;
        return $urandom_range(0, 1) ? 32767 : 0;
    endfunction

    // Send one command beat, with bursts and random gaps on the sender side.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input draw_fields_t f);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= f;
        do @(posedge clk); while (!s_axis_tready);
        predict_command(cmd, f);
        items_sent++;
    endtask

    // A read outside the frame follows every earlier command through the engine;
    // once its beat is back, the engine is idle.
    task automatic wait_idle();
        send_cmd(ffe_pkg::CMD_READ, make_fields(-1, -1, 0, 0, 0, 0, '0));
        s_axis_tvalid <= 1'b0;
        while (read_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both size registers back to back.
    task automatic set_fb_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= ffe_pkg::REG_FB_WIDTH;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        fb_w_cfg = w;
        cfg_index <= ffe_pkg::REG_FB_HEIGHT;
        cfg_data  <= h;
        do @(posedge clk); while (!cfg_ready);
        fb_h_cfg = h;
        cfg_valid <= 1'b0;
        sizes_used++;
    endtask

    // Full 256 x 256 frame after reset: clear, corner pixels, out-of-range accesses.
    task automatic test_full_frame();
        send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(ffe_pkg::CMD_WRITE, make_fields(0, 0, 0, 0, 0, 0, 32'h0000_0000));
        send_cmd(ffe_pkg::CMD_WRITE, make_fields(255, 255, 0, 0, 0, 0, 32'h8000_0001));
        send_cmd(ffe_pkg::CMD_WRITE, make_fields(256, 255, 0, 0, 0, 0, 32'h1234_5678));
        send_cmd(ffe_pkg::CMD_READ, make_fields(255, 255, 0, 0, 0, 0, '0));
        send_cmd(ffe_pkg::CMD_READ, make_fields(0, 0, 0, 0, 0, 0, '0));
        send_cmd(ffe_pkg::CMD_READ, make_fields(-32768, 32767, 0, 0, 0, 0, '0));
    endtask

    // Clipping of rectangles and lines on a small frame, plus ignored commands.
    task automatic test_shape_clipping();
        wait_idle();
        set_fb_size(9'd40, 9'd30);
        send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 32'h0000_0011));
        send_cmd(ffe_pkg::CMD_FILL, make_fields(-5, -5, 0, 0, 10, 10, 32'h0000_0022));
        send_cmd(ffe_pkg::CMD_FILL, make_fields(35, 25, 0, 0, 32767, 32767, 32'h0000_0033));
        send_cmd(ffe_pkg::CMD_FILL, make_fields(10, 10, 0, 0, 0, 5, 32'hDEAD_0000));
        send_cmd(ffe_pkg::CMD_FILL, make_fields(10, 10, 0, 0, 5, -32768, 32'hDEAD_0001));
        send_cmd(ffe_pkg::CMD_FILL, make_fields(100, 100, 0, 0, 4, 4, 32'hDEAD_0002));
        send_cmd(ffe_pkg::CMD_LINE, make_fields(-32768, 3, 32767, 3, 0, 0, 32'h0000_0044));
        send_cmd(ffe_pkg::CMD_LINE, make_fields(7, 32767, 7, -32768, 0, 0, 32'h0000_0055));
        send_cmd(ffe_pkg::CMD_LINE, make_fields(20, 20, 20, 20, 0, 0, 32'h0000_0066));
        send_cmd(ffe_pkg::CMD_LINE, make_fields(1, 1, 5, 9, 0, 0, 32'hDEAD_0003));
        send_cmd(CMD_UNUSED_FIRST, make_fields(2, 2, 2, 2, 1, 1, 32'hDEAD_0004));
        send_cmd(CMD_UNUSED_LAST, make_fields(3, 3, 3, 3, 1, 1, 32'hDEAD_0005));
        send_cmd(ffe_pkg::CMD_READ, make_fields(4, 4, 0, 0, 0, 0, '0));
        send_cmd(ffe_pkg::CMD_READ, make_fields(39, 29, 0, 0, 0, 0, '0));
        send_cmd(ffe_pkg::CMD_READ, make_fields(7, 3, 0, 0, 0, 0, '0));
        send_cmd(ffe_pkg::CMD_READ, make_fields(3, 7, 0, 0, 0, 0, '0));
    endtask

    // Empty frames, a stride change and the largest register values.
    task automatic test_size_extremes();
        wait_idle();
        set_fb_size(9'd0, 9'd256);
        send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 32'hBAD0_0000));
        send_cmd(ffe_pkg::CMD_WRITE, make_fields(0, 0, 0, 0, 0, 0, 32'hBAD0_0001));
        send_cmd(ffe_pkg::CMD_READ, make_fields(0, 0, 0, 0, 0, 0, '0));
        wait_idle();
        set_fb_size(9'd16, 9'd16);
        send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 32'h0000_0077));
        send_cmd(ffe_pkg::CMD_WRITE, make_fields(3, 10, 0, 0, 0, 0, 32'h0000_0088));
        // A narrower stride maps the pixel written above to another coordinate.
        wait_idle();
        set_fb_size(9'd8, 9'd511);
        send_cmd(ffe_pkg::CMD_READ, make_fields(3, 20, 0, 0, 0, 0, '0));
        wait_idle();
        set_fb_size(9'd511, 9'd1);
        send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, 32'h0000_0099));
        send_cmd(ffe_pkg::CMD_READ, make_fields(255, 0, 0, 0, 0, 0, '0));
        wait_idle();
        set_fb_size(9'd1, 9'd0);
        send_cmd(ffe_pkg::CMD_READ, make_fields(0, 0, 0, 0, 0, 0, '0));
    endtask

    // Random command phases, each with its own frame size and idling styles.
    task automatic test_random_phases();
        int phase;
        int n;
        int pick;
        int cols;
        int rows;
        int x;
        int y;
        int sw;
        int sh;
        int tries;
        bit found;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic [COLOR_W-1:0] c;
        for (phase = 0; phase < 11; phase++)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    w = CFG_DATA_W'($urandom_range(1, 40));
                    h = CFG_DATA_W'($urandom_range(1, 40));
                end
                1:
                begin
                    w = CFG_DATA_W'($urandom_range(1, 24));
                    h = CFG_DATA_W'($urandom_range(200, 511));
                end
                2:
                begin
                    w = CFG_DATA_W'($urandom_range(200, 511));
                    h = CFG_DATA_W'($urandom_range(1, 24));
                end
                default:
                begin
                    w = CFG_DATA_W'($urandom_range(0, 64));
                    h = CFG_DATA_W'($urandom_range(0, 64));
                end
            endcase
            set_fb_size(w, h);
            gaps_on = (phase % 3) != 0;
            rx_mode = rx_style_t'(phase % 4);
            send_cmd(ffe_pkg::CMD_CLEAR, make_fields(0, 0, 0, 0, 0, 0, $urandom()));
            cols = vis_cols();
            rows = vis_rows();
            for (n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 99);
                c = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom();
                if (pick < 3)
                    send_cmd(ffe_pkg::CMD_CLEAR, make_fields(rand_coord(cols), rand_coord(rows),
                             0, 0, 0, 0, c));
                else if (pick < 25)
                    send_cmd(ffe_pkg::CMD_WRITE, make_fields(rand_coord(cols), rand_coord(rows),
                             rand_coord(cols), rand_coord(rows), 0, 0, c));
                else if (pick < 50)
                begin
                    // Reads aim near fresh pixels and never at a word not yet written.
                    found = 1'b0;
                    for (tries = 0; tries < 8 && !found; tries++)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            x = last_x + int'($urandom_range(0, 4)) - 2;
                            y = last_y + int'($urandom_range(0, 4)) - 2;
                        end
                        else
                        begin
                            x = rand_coord(cols);
                            y = rand_coord(rows);
                        end
                        found = !on_screen(x, y) || pix_written[pix_addr(x, y)];
                    end
                    if (!found)
                    begin
                        x = -32768;
                        y = rand_coord(rows);
                    end
                    send_cmd(ffe_pkg::CMD_READ, make_fields(x, y, 0, 0, 0, 0, $urandom()));
                end
                else if (pick < 72)
                begin
                    sw = $urandom_range(1, 12);
                    sh = $urandom_range(1, 12);
                    if ($urandom_range(0, 9) == 0)
                        sw = -int'($urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0)
                        sh = -int'($urandom_range(0, 3));
                    if ($urandom_range(0, 19) == 0)
                        sw = int'($signed(16'($urandom())));
                    send_cmd(ffe_pkg::CMD_FILL, make_fields(rand_coord(cols), rand_coord(rows),
                             0, 0, sw, sh, c));
                end
                else if (pick < 92)
                begin
                    x = rand_coord(cols);
                    y = rand_coord(rows);
                    case ($urandom_range(0, 9))
                        0: send_cmd(ffe_pkg::CMD_LINE, make_fields(x, y, rand_coord(cols),
                                    rand_coord(rows), 0, 0, c));
                        1, 2, 3, 4: send_cmd(ffe_pkg::CMD_LINE,
                                             make_fields(x, y, rand_coord(cols), y, 0, 0, c));
                        default: send_cmd(ffe_pkg::CMD_LINE,
                                          make_fields(x, y, x, rand_coord(rows), 0, 0, c));
                    endcase
                end
                else if (pick < 95)
                    send_cmd(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                             draw_fields_t'({$urandom(), $urandom(), $urandom(), $urandom()}));
                else if (pick < 99)
                begin
                    // Noise: every field random; a read is left out to keep its target defined.
                    pick = $urandom_range(0, 2);
                    send_cmd((pick == 0) ? ffe_pkg::CMD_WRITE :
                             ((pick == 1) ? ffe_pkg::CMD_FILL : ffe_pkg::CMD_LINE),
                             draw_fields_t'({$urandom(), $urandom(), $urandom(), $urandom()}));
                end
                else
                    wait_idle();
            end
        end
    endtask

    // Run timeout.
    initial
    begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_frame();
        test_shape_clipping();
        test_size_extremes();
        test_random_phases();
        wait_idle();
        repeat (16) @(posedge clk);
        $display("Covered %0d command beats and %0d read-back beats over %0d frame sizes,",
                 items_sent, reads_checked, sizes_used);
        $display("with clipping, empty frames, stride changes and idling on both sides.");
        if (fail_count == 0 && read_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
